[rtl/core/kmstk_pkg.sv]
package kmstk_pkg;

	// Field widths of one input item and one result item.
	localparam int SIZE_W  = 48;
	localparam int ENC_W   = 4;
	localparam int KIND_W  = 3;
	localparam int KEY_W   = 32;
	localparam int ROW_W   = 4;
	localparam int RANK_W  = 5;
	localparam int MEM_W   = 64;
	localparam int COUNT_W = 32;

	// Default configuration of the top list and the statistics tables.
	localparam int DEF_TOP_K         = 16;
	localparam int DEF_NUM_ENCODINGS = 16;
	localparam int DEF_NUM_KINDS     = 5;

	// Operation codes carried by the func field.
	localparam logic FUNC_RECORD = 1'b0;
	localparam logic FUNC_READ   = 1'b1;

endpackage

[rtl/core/key_memory_stats_top_k.sv]
// Flow: an accepted item is held in the input register, and its result is then held in the
// result register, which drives the outputs, until the receiver takes it.
// Throughput: one item per cycle unless out_stall holds the result register; each
// item does its work in a single pass through the input register, one parallel
// compare against all top slots and one update of the accumulators that it hits.
// Reset: arst_n clears the top list, all sums and counts and both valid flags.
module key_memory_stats_top_k #(
	parameter int TOP_K         = kmstk_pkg::DEF_TOP_K,
	parameter int NUM_ENCODINGS = kmstk_pkg::DEF_NUM_ENCODINGS,
	parameter int NUM_KINDS     = kmstk_pkg::DEF_NUM_KINDS
) (
	input  logic                            clk,
	input  logic                            arst_n,

	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            func,
	input  logic [kmstk_pkg::SIZE_W-1:0]    size_bytes,
	input  logic [kmstk_pkg::ENC_W-1:0]     encoding_code,
	input  logic [kmstk_pkg::KIND_W-1:0]    type_index,
	input  logic [kmstk_pkg::KEY_W-1:0]     key_handle,
	input  logic [kmstk_pkg::ROW_W-1:0]     row_index,

	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            inserted,
	output logic [kmstk_pkg::RANK_W-1:0]    rank,
	output logic [kmstk_pkg::MEM_W-1:0]     grand_memory,
	output logic [kmstk_pkg::COUNT_W-1:0]   grand_keys,
	output logic [kmstk_pkg::SIZE_W-1:0]    slot_size,
	output logic [kmstk_pkg::KEY_W-1:0]     slot_key,
	output logic [kmstk_pkg::MEM_W-1:0]     enc_memory,
	output logic [kmstk_pkg::COUNT_W-1:0]   enc_keys,
	output logic [kmstk_pkg::MEM_W-1:0]     kind_memory,
	output logic [kmstk_pkg::COUNT_W-1:0]   kind_keys
);

	localparam int TOP_AW  = (TOP_K > 1) ? $clog2(TOP_K) : 1;
	localparam int ENC_AW  = (NUM_ENCODINGS > 1) ? $clog2(NUM_ENCODINGS) : 1;
	localparam int KIND_AW = (NUM_KINDS > 1) ? $clog2(NUM_KINDS) : 1;
	localparam logic [kmstk_pkg::RANK_W-1:0] RANK_NONE = kmstk_pkg::RANK_W'(TOP_K);
	localparam logic [kmstk_pkg::COUNT_W-1:0] COUNT_MAX = '1;

	// Input register.
	logic                            valid_s1;
	logic                            func_s1;
	logic [kmstk_pkg::SIZE_W-1:0]    size_s1;
	logic [kmstk_pkg::ENC_W-1:0]     enc_s1;
	logic [kmstk_pkg::KIND_W-1:0]    kind_s1;
	logic [kmstk_pkg::KEY_W-1:0]     key_s1;
	logic [kmstk_pkg::ROW_W-1:0]     row_s1;

	// Result register.
	logic                            valid_s2;
	logic                            inserted_s2;
	logic [kmstk_pkg::RANK_W-1:0]    rank_s2;
	logic [kmstk_pkg::MEM_W-1:0]     grand_mem_s2;
	logic [kmstk_pkg::COUNT_W-1:0]   grand_keys_s2;
	logic [kmstk_pkg::SIZE_W-1:0]    slot_size_s2;
	logic [kmstk_pkg::KEY_W-1:0]     slot_key_s2;
	logic [kmstk_pkg::MEM_W-1:0]     enc_mem_s2;
	logic [kmstk_pkg::COUNT_W-1:0]   enc_keys_s2;
	logic [kmstk_pkg::MEM_W-1:0]     kind_mem_s2;
	logic [kmstk_pkg::COUNT_W-1:0]   kind_keys_s2;

	// Statistics state.
	logic [kmstk_pkg::SIZE_W-1:0]    top_size_q [TOP_K];
	logic [kmstk_pkg::KEY_W-1:0]     top_key_q [TOP_K];
	logic [kmstk_pkg::MEM_W-1:0]     enc_mem_q [NUM_ENCODINGS];
	logic [kmstk_pkg::COUNT_W-1:0]   enc_keys_q [NUM_ENCODINGS];
	logic [kmstk_pkg::MEM_W-1:0]     kind_mem_q [NUM_KINDS];
	logic [kmstk_pkg::COUNT_W-1:0]   kind_keys_q [NUM_KINDS];
	logic [kmstk_pkg::MEM_W-1:0]     total_mem_q;
	logic [kmstk_pkg::COUNT_W-1:0]   total_count_q;

	// Combinational work for the item in the input register.
	logic                            advance;
	logic                            is_record;
	logic                            do_insert;
	logic [TOP_K-1:0]                not_greater;
	logic [TOP_K-1:0]                first_hit;
	logic [TOP_AW-1:0]               ins_pos;
	logic [kmstk_pkg::SIZE_W-1:0]    top_size_n [TOP_K];
	logic [kmstk_pkg::KEY_W-1:0]     top_key_n [TOP_K];
	logic [kmstk_pkg::ROW_W-1:0]     enc_addr;
	logic [kmstk_pkg::ROW_W-1:0]     kind_addr;
	logic                            enc_in_range;
	logic                            kind_in_range;
	logic                            slot_in_range;
	logic [ENC_AW-1:0]               enc_idx;
	logic [KIND_AW-1:0]              kind_idx;
	logic [TOP_AW-1:0]               slot_idx;
	logic [kmstk_pkg::MEM_W-1:0]     enc_mem_cur;
	logic [kmstk_pkg::COUNT_W-1:0]   enc_keys_cur;
	logic [kmstk_pkg::MEM_W-1:0]     kind_mem_cur;
	logic [kmstk_pkg::COUNT_W-1:0]   kind_keys_cur;
	logic [kmstk_pkg::MEM_W-1:0]     size_ext;
	logic [kmstk_pkg::MEM_W-1:0]     total_mem_n;
	logic [kmstk_pkg::COUNT_W-1:0]   total_count_n;
	logic [kmstk_pkg::MEM_W-1:0]     enc_mem_n;
	logic [kmstk_pkg::COUNT_W-1:0]   enc_keys_n;
	logic [kmstk_pkg::MEM_W-1:0]     kind_mem_n;
	logic [kmstk_pkg::COUNT_W-1:0]   kind_keys_n;

	// Handshake: the input register moves on whenever the result register is free or drains.
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			func_s1 <= func;
			size_s1 <= size_bytes;
			enc_s1  <= encoding_code;
			kind_s1 <= type_index;
			key_s1  <= key_handle;
			row_s1  <= row_index;
		end
	end

	assign is_record = (func_s1 == kmstk_pkg::FUNC_RECORD);

	// Compare the new size against every slot; the list is sorted, so the hits form a tail.
	always_comb begin
		for (int i = 0; i < TOP_K; i++) begin
			not_greater[i] = (top_size_q[i] <= size_s1);
		end
		first_hit[0] = not_greater[0];
		for (int i = 1; i < TOP_K; i++) begin
			first_hit[i] = not_greater[i] && !not_greater[i-1];
		end
	end

	assign do_insert = is_record && (size_s1 > top_size_q[TOP_K-1]);

	// Encode the insert position from the one-hot first hit.
	always_comb begin
		ins_pos = '0;
		for (int i = 0; i < TOP_K; i++) begin
			if (first_hit[i]) begin
				ins_pos = ins_pos | TOP_AW'(i);
			end
		end
	end

	// Next contents of the top list: slots from the insert point shift down by one.
	always_comb begin
		for (int i = 0; i < TOP_K; i++) begin
			top_size_n[i] = top_size_q[i];
			top_key_n[i]  = top_key_q[i];
		end
		if (do_insert) begin
			if (first_hit[0]) begin
				top_size_n[0] = size_s1;
				top_key_n[0]  = key_s1;
			end
			for (int i = 1; i < TOP_K; i++) begin
				if (first_hit[i]) begin
					top_size_n[i] = size_s1;
					top_key_n[i]  = key_s1;
				end else if (not_greater[i]) begin
					top_size_n[i] = top_size_q[i-1];
					top_key_n[i]  = top_key_q[i-1];
				end
			end
		end
	end

	// One table lookup serves both the record update and the read.
	assign enc_addr  = is_record ? enc_s1 : row_s1;
	assign kind_addr = is_record ? {1'b0, kind_s1} : row_s1;

	assign enc_in_range  = (32'(enc_addr) < NUM_ENCODINGS);
	assign kind_in_range = (32'(kind_addr) < NUM_KINDS);
	assign slot_in_range = (32'(row_s1) < TOP_K);

	assign enc_idx  = ENC_AW'(enc_addr);
	assign kind_idx = KIND_AW'(kind_addr);
	assign slot_idx = TOP_AW'(row_s1);

	always_comb begin
		enc_mem_cur   = '0;
		enc_keys_cur  = '0;
		kind_mem_cur  = '0;
		kind_keys_cur = '0;
		if (enc_in_range) begin
			enc_mem_cur  = enc_mem_q[enc_idx];
			enc_keys_cur = enc_keys_q[enc_idx];
		end
		if (kind_in_range) begin
			kind_mem_cur  = kind_mem_q[kind_idx];
			kind_keys_cur = kind_keys_q[kind_idx];
		end
	end

	// Accumulator updates: sums wrap, counts saturate.
	assign size_ext      = kmstk_pkg::MEM_W'(size_s1);
	assign total_mem_n   = total_mem_q + size_ext;
	assign total_count_n = (total_count_q == COUNT_MAX) ? total_count_q : total_count_q + 1'b1;
	assign enc_mem_n     = enc_mem_cur + size_ext;
	assign enc_keys_n    = (enc_keys_cur == COUNT_MAX) ? enc_keys_cur : enc_keys_cur + 1'b1;
	assign kind_mem_n    = kind_mem_cur + size_ext;
	assign kind_keys_n   = (kind_keys_cur == COUNT_MAX) ? kind_keys_cur : kind_keys_cur + 1'b1;

	// State update when a record item leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TOP_K; i++) begin
				top_size_q[i] <= '0;
				top_key_q[i]  <= '0;
			end
			for (int i = 0; i < NUM_ENCODINGS; i++) begin
				enc_mem_q[i]  <= '0;
				enc_keys_q[i] <= '0;
			end
			for (int i = 0; i < NUM_KINDS; i++) begin
				kind_mem_q[i]  <= '0;
				kind_keys_q[i] <= '0;
			end
			total_mem_q   <= '0;
			total_count_q <= '0;
		end else if (advance && is_record) begin
			for (int i = 0; i < TOP_K; i++) begin
				top_size_q[i] <= top_size_n[i];
				top_key_q[i]  <= top_key_n[i];
			end
			if (enc_in_range) begin
				enc_mem_q[enc_idx]  <= enc_mem_n;
				enc_keys_q[enc_idx] <= enc_keys_n;
			end
			if (kind_in_range) begin
				kind_mem_q[kind_idx]  <= kind_mem_n;
				kind_keys_q[kind_idx] <= kind_keys_n;
			end
			total_mem_q   <= total_mem_n;
			total_count_q <= total_count_n;
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	// Result payload: grand figures after the item, row figures on a read only.
	always_ff @(posedge clk) begin
		if (advance) begin
			inserted_s2  <= do_insert;
			rank_s2      <= do_insert ? kmstk_pkg::RANK_W'(ins_pos) : RANK_NONE;
			slot_size_s2 <= '0;
			slot_key_s2  <= '0;
			enc_mem_s2   <= '0;
			enc_keys_s2  <= '0;
			kind_mem_s2  <= '0;
			kind_keys_s2 <= '0;
			if (is_record) begin
				grand_mem_s2  <= total_mem_n;
				grand_keys_s2 <= total_count_n;
			end else begin
				grand_mem_s2  <= total_mem_q;
				grand_keys_s2 <= total_count_q;
				if (slot_in_range) begin
					slot_size_s2 <= top_size_q[slot_idx];
					slot_key_s2  <= top_key_q[slot_idx];
				end
				enc_mem_s2   <= enc_mem_cur;
				enc_keys_s2  <= enc_keys_cur;
				kind_mem_s2  <= kind_mem_cur;
				kind_keys_s2 <= kind_keys_cur;
			end
		end
	end

	assign out_valid    = valid_s2;
	assign inserted     = inserted_s2;
	assign rank         = rank_s2;
	assign grand_memory = grand_mem_s2;
	assign grand_keys   = grand_keys_s2;
	assign slot_size    = slot_size_s2;
	assign slot_key     = slot_key_s2;
	assign enc_memory   = enc_mem_s2;
	assign enc_keys     = enc_keys_s2;
	assign kind_memory  = kind_mem_s2;
	assign kind_keys    = kind_keys_s2;

endmodule

[tb/sv/key_memory_stats_top_k_test.sv]
module key_memory_stats_top_k_test;

	localparam int SIZE_W  = kmstk_pkg::SIZE_W;
	localparam int ENC_W   = kmstk_pkg::ENC_W;
	localparam int KIND_W  = kmstk_pkg::KIND_W;
	localparam int KEY_W   = kmstk_pkg::KEY_W;
	localparam int ROW_W   = kmstk_pkg::ROW_W;
	localparam int RANK_W  = kmstk_pkg::RANK_W;
	localparam int MEM_W   = kmstk_pkg::MEM_W;
	localparam int COUNT_W = kmstk_pkg::COUNT_W;

	localparam int TOP_K         = kmstk_pkg::DEF_TOP_K;
	localparam int NUM_ENCODINGS = kmstk_pkg::DEF_NUM_ENCODINGS;
	localparam int NUM_KINDS     = kmstk_pkg::DEF_NUM_KINDS;

	localparam int CLK_PERIOD   = 12;
	localparam int RESET_CYCLES = 6;
	localparam int RANDOM_ITEMS = 1900;
	localparam int HOLD_CYCLES  = 80;
	localparam int DRAIN_LIMIT  = 5000;
	localparam int TAIL_CYCLES  = 8;
	localparam int LIMIT_CYCLES = 400000;

	localparam logic [SIZE_W-1:0] SIZE_MAX = '1;

	// One input item as the sender offers it.
	typedef struct packed {
		logic              func;
		logic [SIZE_W-1:0] size;
		logic [ENC_W-1:0]  enc;
		logic [KIND_W-1:0] kind;
		logic [KEY_W-1:0]  key;
		logic [ROW_W-1:0]  row;
	} key_item_t;

	// One result item as the block returns it.
	typedef struct packed {
		logic               inserted;
		logic [RANK_W-1:0]  rank;
		logic [MEM_W-1:0]   grand_memory;
		logic [COUNT_W-1:0] grand_keys;
		logic [SIZE_W-1:0]  slot_size;
		logic [KEY_W-1:0]   slot_key;
		logic [MEM_W-1:0]   enc_memory;
		logic [COUNT_W-1:0] enc_keys;
		logic [MEM_W-1:0]   kind_memory;
		logic [COUNT_W-1:0] kind_keys;
	} key_result_t;

	// Keeps its own copy of the statistics tables and the top list, and the
	// results still owed by the block, oldest first.
	class key_stats_scoreboard;
		logic [SIZE_W-1:0]  top_sizes [TOP_K];
		logic [KEY_W-1:0]   top_keys [TOP_K];
		logic [MEM_W-1:0]   enc_mem [NUM_ENCODINGS];
		logic [COUNT_W-1:0] enc_count [NUM_ENCODINGS];
		logic [MEM_W-1:0]   kind_mem [NUM_KINDS];
		logic [COUNT_W-1:0] kind_count [NUM_KINDS];
		logic [MEM_W-1:0]   total_mem;
		logic [COUNT_W-1:0] total_count;
		key_result_t        owed_results [$];
		int                 mismatches;
		int                 results_seen;

		function new();
			foreach (top_sizes[i]) begin
				top_sizes[i] = '0;
				top_keys[i] = '0;
			end
			foreach (enc_mem[i]) begin
				enc_mem[i] = '0;
				enc_count[i] = '0;
			end
			foreach (kind_mem[i]) begin
				kind_mem[i] = '0;
				kind_count[i] = '0;
			end
			total_mem = '0;
			total_count = '0;
			mismatches = 0;
			results_seen = 0;
		endfunction

		function logic [COUNT_W-1:0] bump_count(logic [COUNT_W-1:0] v);
			return (v == '1) ? v : v + 1'b1;
		endfunction

		// Applies one item to the tables and returns the result it causes.
		function key_result_t update_stats(key_item_t it);
			key_result_t r;
			int pos;
			r = '0;
			r.rank = RANK_W'(TOP_K);
			if (it.func == kmstk_pkg::FUNC_RECORD) begin
				total_mem = total_mem + MEM_W'(it.size);
				total_count = bump_count(total_count);
				if (it.enc < NUM_ENCODINGS) begin
					enc_mem[it.enc] = enc_mem[it.enc] + MEM_W'(it.size);
					enc_count[it.enc] = bump_count(enc_count[it.enc]);
				end
				if (it.kind < NUM_KINDS) begin
					kind_mem[it.kind] = kind_mem[it.kind] + MEM_W'(it.size);
					kind_count[it.kind] = bump_count(kind_count[it.kind]);
				end
				// A larger size goes in front of the first slot that is not larger,
				// so a new record wins a tie against the entries already held.
				if (it.size > top_sizes[TOP_K-1]) begin
					pos = TOP_K - 1;
					for (int i = TOP_K - 1; i >= 0; i--) begin
						if (top_sizes[i] <= it.size) pos = i;
					end
					for (int i = TOP_K - 1; i > pos; i--) begin
						top_sizes[i] = top_sizes[i-1];
						top_keys[i] = top_keys[i-1];
					end
					top_sizes[pos] = it.size;
					top_keys[pos] = it.key;
					r.inserted = 1'b1;
					r.rank = RANK_W'(pos);
				end
			end else begin
				if (it.row < TOP_K) begin
					r.slot_size = top_sizes[it.row];
					r.slot_key = top_keys[it.row];
				end
				if (it.row < NUM_ENCODINGS) begin
					r.enc_memory = enc_mem[it.row];
					r.enc_keys = enc_count[it.row];
				end
				if (it.row < NUM_KINDS) begin
					r.kind_memory = kind_mem[it.row];
					r.kind_keys = kind_count[it.row];
				end
			end
			r.grand_memory = total_mem;
			r.grand_keys = total_count;
			return r;
		endfunction

		function void note_item(key_item_t it);
			owed_results.push_back(update_stats(it));
		endfunction

		task report_mismatch(string msg);
			mismatches++;
			$display("mismatch: %s", msg);
		endtask

		task check_field(string name, logic [63:0] got, logic [63:0] want);
			if (got !== want)
				report_mismatch($sformatf("result %0d %s got %0h expected %0h",
					results_seen, name, got, want));
		endtask

		task check_result(key_result_t got);
			key_result_t want;
			if (owed_results.size() == 0) begin
				report_mismatch($sformatf("result %0d arrived with none expected",
					results_seen));
			end else begin
				want = owed_results.pop_front();
				check_field("inserted", 64'(got.inserted), 64'(want.inserted));
				check_field("rank", 64'(got.rank), 64'(want.rank));
				check_field("grand_memory", got.grand_memory, want.grand_memory);
				check_field("grand_keys", 64'(got.grand_keys), 64'(want.grand_keys));
				check_field("slot_size", 64'(got.slot_size), 64'(want.slot_size));
				check_field("slot_key", 64'(got.slot_key), 64'(want.slot_key));
				check_field("enc_memory", got.enc_memory, want.enc_memory);
				check_field("enc_keys", 64'(got.enc_keys), 64'(want.enc_keys));
				check_field("kind_memory", got.kind_memory, want.kind_memory);
				check_field("kind_keys", 64'(got.kind_keys), 64'(want.kind_keys));
			end
			results_seen++;
		endtask
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic               func;
	logic [SIZE_W-1:0]  size_bytes;
	logic [ENC_W-1:0]   encoding_code;
	logic [KIND_W-1:0]  type_index;
	logic [KEY_W-1:0]   key_handle;
	logic [ROW_W-1:0]   row_index;
	logic               out_valid;
	logic               out_stall;
	logic               inserted;
	logic [RANK_W-1:0]  rank;
	logic [MEM_W-1:0]   grand_memory;
	logic [COUNT_W-1:0] grand_keys;
	logic [SIZE_W-1:0]  slot_size;
	logic [KEY_W-1:0]   slot_key;
	logic [MEM_W-1:0]   enc_memory;
	logic [COUNT_W-1:0] enc_keys;
	logic [MEM_W-1:0]   kind_memory;
	logic [COUNT_W-1:0] kind_keys;

	key_stats_scoreboard sb;

	// Shared pacing controls between the sequence, the sender and the receiver.
	bit quiet;
	bit hold_req;
	bit hold_busy;

	key_memory_stats_top_k #(
		.TOP_K(TOP_K),
		.NUM_ENCODINGS(NUM_ENCODINGS),
		.NUM_KINDS(NUM_KINDS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func(func),
		.size_bytes(size_bytes),
		.encoding_code(encoding_code),
		.type_index(type_index),
		.key_handle(key_handle),
		.row_index(row_index),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.inserted(inserted),
		.rank(rank),
		.grand_memory(grand_memory),
		.grand_keys(grand_keys),
		.slot_size(slot_size),
		.slot_key(slot_key),
		.enc_memory(enc_memory),
		.enc_keys(enc_keys),
		.kind_memory(kind_memory),
		.kind_keys(kind_keys)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Hard limit on the length of the run.
	initial begin
		#(CLK_PERIOD * LIMIT_CYCLES);
		$display("== FAIL ==");
		$finish;
	end

	// Mostly no gap, some short ones, a few long ones.
	function automatic int pick_gap();
		int r;
		if (quiet || hold_req || hold_busy) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	// Sizes that cover all 48 bits, small values, and values next to sizes
	// already in the top list so that ties and deep inserts keep happening.
	function automatic logic [SIZE_W-1:0] pick_size();
		logic [63:0] wide;
		logic [63:0] mask;
		int r;
		int w;
		r = $urandom_range(0, 99);
		wide = {$urandom, $urandom};
		if (r < 15) return wide[SIZE_W-1:0];
		if (r < 40) begin
			wide = 64'(sb.top_sizes[$urandom_range(0, TOP_K - 1)]);
			return SIZE_W'(wide + 64'($urandom_range(0, 2)) - 64'd1);
		end
		if (r < 50) return SIZE_W'($urandom_range(0, 3));
		w = $urandom_range(1, SIZE_W);
		mask = (64'd1 << w) - 64'd1;
		return SIZE_W'(wide & mask);
	endfunction

	function automatic key_item_t random_item();
		key_item_t it;
		it.func = ($urandom_range(0, 99) < 25) ? kmstk_pkg::FUNC_READ : kmstk_pkg::FUNC_RECORD;
		it.size = pick_size();
		it.enc = ENC_W'($urandom_range(0, 15));
		if ($urandom_range(0, 9) < 8) it.kind = KIND_W'($urandom_range(0, NUM_KINDS - 1));
		else it.kind = KIND_W'($urandom_range(NUM_KINDS, 7));
		it.key = $urandom;
		it.row = ROW_W'($urandom_range(0, 15));
		return it;
	endfunction

	// Offers one item after a random gap and holds it until it is taken.
	task send_item(input key_item_t it);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		func <= it.func;
		size_bytes <= it.size;
		encoding_code <= it.enc;
		type_index <= it.kind;
		key_handle <= it.key;
		row_index <= it.row;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		sb.note_item(it);
	endtask

	task send_record(input logic [SIZE_W-1:0] size, input logic [ENC_W-1:0] enc,
			input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] key);
		key_item_t it;
		it = random_item();
		it.func = kmstk_pkg::FUNC_RECORD;
		it.size = size;
		it.enc = enc;
		it.kind = kind;
		it.key = key;
		send_item(it);
	endtask

	task send_read(input logic [ROW_W-1:0] row);
		key_item_t it;
		it = random_item();
		it.func = kmstk_pkg::FUNC_READ;
		it.row = row;
		send_item(it);
	endtask

	// Receiver: random stall pattern, with a long hold-off when asked for one.
	initial begin
		bit level;
		int span;
		int r;
		out_stall = 1'b0;
		@(negedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				hold_busy = 1'b1;
				level = 1'b1;
				span = HOLD_CYCLES;
			end else if (quiet) begin
				hold_busy = 1'b0;
				level = 1'b0;
				span = 1;
			end else begin
				hold_busy = 1'b0;
				r = $urandom_range(0, 99);
				level = (r >= 60);
				if (r < 60) span = $urandom_range(1, 8);
				else if (r < 95) span = $urandom_range(1, 3);
				else span = $urandom_range(10, 30);
			end
			out_stall <= level;
			repeat (span) @(negedge clk);
		end
	end

	// Every result taken by the receiver is checked against the oldest one owed.
	always @(posedge clk) begin : result_monitor
		key_result_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.inserted = inserted;
			got.rank = rank;
			got.grand_memory = grand_memory;
			got.grand_keys = grand_keys;
			got.slot_size = slot_size;
			got.slot_key = slot_key;
			got.enc_memory = enc_memory;
			got.enc_keys = enc_keys;
			got.kind_memory = kind_memory;
			got.kind_keys = kind_keys;
			sb.check_result(got);
		end
	end

	// Main sequence.
	initial begin
		int drain;
		sb = new();
		quiet = 1'b0;
		hold_req = 1'b0;
		hold_busy = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = kmstk_pkg::FUNC_RECORD;
		size_bytes = '0;
		encoding_code = '0;
		type_index = '0;
		key_handle = '0;
		row_index = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part: empty table, zero size, extremes, ties at the top and
		// in the middle, unknown types, a full list and a tie with the last slot.
		send_read(4'd0);
		send_record(48'd0, 4'd0, 3'd0, 32'h0000_0000);
		send_record(SIZE_MAX, 4'd15, 3'd4, 32'hFFFF_FFFF);
		send_record(48'd1, 4'd1, 3'd5, 32'h0000_0001);
		send_record(48'd1, 4'd2, 3'd6, 32'h0000_0002);
		send_record(48'd1000, 4'd3, 3'd7, 32'h0000_0003);
		send_record(SIZE_MAX, 4'd4, 3'd1, 32'hA5A5_5A5A);
		send_record(48'h8000_0000_0000, 4'd5, 3'd2, 32'h8000_0000);
		send_record(48'h5555_5555_5555, 4'd6, 3'd3, 32'h7FFF_FFFF);
		for (int n = 0; n < 9; n++)
			send_record(SIZE_W'(2000 + n * 37), ENC_W'(7 + n), KIND_W'(n % NUM_KINDS), $urandom);
		send_record(sb.top_sizes[TOP_K-1], 4'd0, 3'd0, 32'h1234_5678);
		send_read(4'd0);
		send_read(4'd4);
		send_read(4'd5);
		send_read(4'd15);
		send_read(4'd9);

		// Random part, with two long receiver hold-offs and a stretch with no
		// idling on either side.
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == 100 || i == 1200) hold_req = 1'b1;
			quiet = (i >= 400 && i < 600);
			send_item(random_item());
		end
		quiet = 1'b0;
		@(negedge clk);
		in_valid <= 1'b0;

		// Wait for the results still owed, then a few more cycles.
		drain = 0;
		while (sb.owed_results.size() != 0 && drain < DRAIN_LIMIT) begin
			@(posedge clk);
			drain++;
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.owed_results.size() != 0)
			sb.report_mismatch($sformatf("%0d results never arrived", sb.owed_results.size()));

		if (sb.mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

[sim.f]
rtl/core/kmstk_pkg.sv
rtl/core/key_memory_stats_top_k.sv
tb/sv/key_memory_stats_top_k_test.sv
